FILE: hw/rtl/tli_pkg.sv
// Shared constants, types and codes of the trie insert and lookup block.
`default_nettype none
package tli_pkg;

  localparam int unsigned MAX_NODES = 16384;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned SYMBOLS   = 27;
  localparam int unsigned SYM_W     = 5;
  localparam int unsigned ID_W      = 16;

  localparam logic [SYM_W-1:0]  SEP_SYMBOL = SYM_W'(26);
  localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(MAX_NODES - 1);

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } tli_status_e;

  typedef struct packed {
    logic             is_query;
    logic [SYM_W-1:0] sym;
    logic             last;
    logic [ID_W-1:0]  id;
  } tli_item_t;

  typedef struct packed {
    tli_status_e     status;
    logic [ID_W-1:0] found_id;
  } tli_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/trie_insert_lookup_max_id.sv
// Array trie over 27 symbols with insert and query of the latest stamped id.
//
// Keys arrive one symbol word at a time on the input queue port: a word is
// taken when push is high and full is low. Each word carries cmd_i (0 insert,
// 1 query), symbol_i (0..25 letters, 26 separator, higher codes act as 26),
// key_last_i and key_id_i. Only the final word of a key produces a result.
// Results leave through the output queue port: status_o and found_id_o are
// valid while empty is low, and a word is taken when pop is high.
// Each symbol passes through S_ISSUE, where its child row is read, and S_EVAL,
// where the engine decides, allocates and stamps; a query's final symbol that
// finds its node also passes through S_STAMP for the stamp read. A result is
// pushed from S_EVAL, or from S_STAMP for a found query, into the registered
// result queue. The engine takes the next symbol only once it is through with
// the current one, set by that read and update loop on the child table banks.
// After reset the child table is cleared, one node row per cycle, over all
// 16384 rows; words are queued meanwhile until full rises. When the receiver
// stalls, results collect in a two-word queue, and then the engine holds any
// final symbol, which in turn backs up the input queue.
`default_nettype none
module trie_insert_lookup_max_id (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      cmd_i,
  input  wire logic [tli_pkg::SYM_W-1:0] symbol_i,
  input  wire logic                      key_last_i,
  input  wire logic [tli_pkg::ID_W-1:0]  key_id_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [1:0]                     status_o,
  output logic [tli_pkg::ID_W-1:0]       found_id_o
);

  logic               item_valid, item_pop, res_push, res_ready;
  tli_pkg::tli_item_t item;
  tli_pkg::tli_res_t  res;

  tli_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_i),
    .symbol_i    (symbol_i),
    .key_last_i  (key_last_i),
    .key_id_i    (key_id_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  tli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_ready_i (res_ready),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  tli_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_ready_o(res_ready),
    .empty_o    (empty),
    .pop_i      (pop),
    .status_o   (status_o),
    .found_id_o (found_id_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tli_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tli_front.sv
// Input side: takes symbol words, saturates the symbol and queues them for the engine.
`default_nettype none
module tli_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  output logic                           full_o,
  input  wire logic                      cmd_i,
  input  wire logic [tli_pkg::SYM_W-1:0] symbol_i,
  input  wire logic                      key_last_i,
  input  wire logic [tli_pkg::ID_W-1:0]  key_id_i,
  output logic                           item_valid_o,
  output tli_pkg::tli_item_t             item_o,
  input  wire logic                      item_pop_i
);

  tli_pkg::tli_item_t slot_q [2];
  tli_pkg::tli_item_t in_item;
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;
  logic               do_push, do_pop;

  always_comb begin
    in_item.is_query = cmd_i;
    // Codes above the separator are treated as the separator.
    in_item.sym      = (symbol_i > tli_pkg::SEP_SYMBOL) ? tli_pkg::SEP_SYMBOL : symbol_i;
    in_item.last     = key_last_i;
    in_item.id       = key_id_i;
  end

  assign full_o       = cnt_q[1];
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tli_resq.sv
// Result queue of two words between the engine and the result port.
`default_nettype none
module tli_resq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     res_push_i,
  input  wire tli_pkg::tli_res_t        res_i,
  output logic                          res_ready_o,
  output logic                          empty_o,
  input  wire logic                     pop_i,
  output logic [1:0]                    status_o,
  output logic [tli_pkg::ID_W-1:0]      found_id_o
);

  tli_pkg::tli_res_t slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign res_ready_o = !cnt_q[1];
  assign empty_o     = (cnt_q == 2'd0);
  assign do_push     = res_push_i && res_ready_o;
  assign do_pop      = pop_i && !empty_o;
  assign status_o    = slot_q[rd_ptr_q].status;
  assign found_id_o  = slot_q[rd_ptr_q].found_id;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tli_back.sv
// Trie engine: child table banks, node stamps and the walk sequencer.
`default_nettype none
module tli_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         item_valid_i,
  input  wire tli_pkg::tli_item_t item_i,
  output logic              item_pop_o,
  input  wire logic         res_ready_i,
  output logic              res_push_o,
  output tli_pkg::tli_res_t res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_ISSUE = 4'b0010,
    S_EVAL  = 4'b0100,
    S_STAMP = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  tli_pkg::tli_item_t         item_q, item_d;
  logic [tli_pkg::NODE_W-1:0] clr_q, clr_d;
  logic [tli_pkg::NODE_W-1:0] cursor_q, cursor_d;
  logic [tli_pkg::NODE_W-1:0] next_free_q, next_free_d;
  logic                       miss_q, miss_d;
  logic                       full_q, full_d;

  logic [tli_pkg::NODE_W-1:0] bank_rd [tli_pkg::SYMBOLS];
  logic [tli_pkg::NODE_W-1:0] child, new_node, eff_child, cur_n;
  logic                       miss_n, full_n, walk, alloc, clearing, stamp_we, found;
  logic [tli_pkg::ID_W-1:0]   stamp_rd;

  assign clearing = (state_q == S_CLEAR);
  assign child    = bank_rd[item_q.sym];
  assign new_node = next_free_q + tli_pkg::NODE_W'(1);
  assign walk     = (state_q == S_EVAL) && !miss_q && !full_q;

  // Walk step for the symbol whose child row has just been read.
  always_comb begin
    cur_n     = cursor_q;
    miss_n    = miss_q;
    full_n    = full_q;
    alloc     = 1'b0;
    stamp_we  = 1'b0;
    eff_child = child;
    if (walk) begin
      if (item_q.is_query) begin
        if (child == '0) begin
          miss_n = 1'b1;
        end else begin
          cur_n = child;
        end
      end else begin
        if (child == '0) begin
          if (next_free_q != tli_pkg::LAST_NODE) begin
            alloc     = 1'b1;
            eff_child = new_node;
          end else begin
            full_n = 1'b1;
          end
        end
        if (eff_child != '0) begin
          cur_n    = eff_child;
          stamp_we = 1'b1;
        end
      end
    end
  end

  assign found = !miss_n && !full_n && (cur_n != '0);

  always_comb begin
    state_d          = state_q;
    item_d           = item_q;
    clr_d            = clr_q;
    cursor_d         = cursor_q;
    next_free_d      = next_free_q;
    miss_d           = miss_q;
    full_d           = full_q;
    item_pop_o       = 1'b0;
    res_push_o       = 1'b0;
    res_o.status     = tli_pkg::ST_INSERTED;
    res_o.found_id   = '0;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + tli_pkg::NODE_W'(1);
        if (clr_q == tli_pkg::LAST_NODE) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // A final symbol is taken only while the result queue has room for it.
        if (item_valid_i && (!item_i.last || res_ready_i)) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cursor_d = cur_n;
        miss_d   = miss_n;
        full_d   = full_n;
        if (alloc) begin
          next_free_d = new_node;
        end
        state_d = S_ISSUE;
        if (item_q.last) begin
          cursor_d = '0;
          miss_d   = 1'b0;
          full_d   = 1'b0;
          if (item_q.is_query) begin
            if (found) begin
              state_d = S_STAMP;
            end else begin
              res_push_o   = 1'b1;
              res_o.status = tli_pkg::ST_NOT_FOUND;
            end
          end else begin
            res_push_o   = 1'b1;
            res_o.status = full_n ? tli_pkg::ST_FULL : tli_pkg::ST_INSERTED;
          end
        end
      end
      S_STAMP: begin
        res_push_o     = 1'b1;
        res_o.status   = tli_pkg::ST_FOUND;
        res_o.found_id = stamp_rd;
        state_d        = S_ISSUE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      next_free_q <= '0;
      miss_q      <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      next_free_q <= next_free_d;
      miss_q      <= miss_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // One bank per symbol, so the clearing pass wipes a whole node row per cycle.
  for (genvar b = 0; b < tli_pkg::SYMBOLS; b++) begin : g_bank
    logic bank_we;
    assign bank_we = clearing || (alloc && (item_q.sym == tli_pkg::SYM_W'(b)));

    tli_ram #(
      .WIDTH(tli_pkg::NODE_W),
      .DEPTH(tli_pkg::MAX_NODES)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we),
      .waddr_i(clearing ? clr_q : cursor_q),
      .wdata_i(clearing ? '0 : new_node),
      .raddr_i(cursor_q),
      .rdata_o(bank_rd[b])
    );
  end

  tli_ram #(
    .WIDTH(tli_pkg::ID_W),
    .DEPTH(tli_pkg::MAX_NODES)
  ) u_stamp (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(eff_child),
    .wdata_i(item_q.id),
    .raddr_i(cur_n),
    .rdata_o(stamp_rd)
  );

endmodule
`default_nettype wire

FILE: tb/trie_checker.sv
// Checker for the trie block: predicts each result word and compares it with the DUT output.
`timescale 1ns / 100ps
module trie_checker
  import tli_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic              full_i,
  input  wire logic              cmd_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic              key_last_i,
  input  wire logic [ID_W-1:0]   key_id_i,
  input  wire logic              empty_i,
  input  wire logic              pop_i,
  input  wire logic [1:0]        status_i,
  input  wire logic [ID_W-1:0]   found_id_i,
  input  wire logic              done_i,
  output int                     fail_count_o
);

  // Predicted trie contents. A zero child entry means no child.
  bit [NODE_W-1:0]   child_tbl [MAX_NODES*SYMBOLS];
  bit [ID_W-1:0]     stamp_tbl [MAX_NODES];
  logic [NODE_W-1:0] walk_node;
  int unsigned       nodes_used;
  logic              walk_miss;
  logic              walk_full;

  tli_res_t  pending_results [$];
  tli_item_t in_word;
  tli_res_t  new_result;
  tli_res_t  want;
  int        mismatch_cnt = 0;
  int        leftover_cnt = 0;

  assign fail_count_o = mismatch_cnt + leftover_cnt;

  // Advances the predicted walk by one symbol word; returns 1 when the word ends a key.
  function automatic bit walk_trie(input tli_item_t w, output tli_res_t r);
    logic [SYM_W-1:0]  s;
    int unsigned       slot;
    logic [NODE_W-1:0] nxt;
    s = (w.sym > SEP_SYMBOL) ? SEP_SYMBOL : w.sym;
    if (!walk_miss && !walk_full) begin
      slot = walk_node * SYMBOLS + s;
      nxt  = child_tbl[slot];
      if (w.is_query) begin
        if (nxt == '0) walk_miss = 1'b1;
        else walk_node = nxt;
      end else begin
        if (nxt == '0) begin
          if (nodes_used + 1 < MAX_NODES) begin
            nodes_used++;
            nxt = NODE_W'(nodes_used);
            child_tbl[slot] = nxt;
          end else begin
            walk_full = 1'b1;
          end
        end
        if (nxt != '0) begin
          walk_node = nxt;
          stamp_tbl[nxt] = w.id;
        end
      end
    end
    r.status   = ST_INSERTED;
    r.found_id = '0;
    if (!w.last) return 1'b0;
    if (w.is_query) begin
      if (walk_miss || walk_full || walk_node == '0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.status   = ST_FOUND;
        r.found_id = stamp_tbl[walk_node];
      end
    end else if (walk_full) begin
      r.status = ST_FULL;
    end
    walk_node = '0;
    walk_miss = 1'b0;
    walk_full = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node  = '0;
      nodes_used = 0;
      walk_miss  = 1'b0;
      walk_full  = 1'b0;
      pending_results.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d found_id %0h",
                 status_i, found_id_i);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatch_cnt++;
          end
          if (found_id_i !== want.found_id) begin
            $error("found_id: expected %0h, got %0h", want.found_id, found_id_i);
            mismatch_cnt++;
          end
        end
      end
      if (push_i && !full_i) begin
        in_word.is_query = cmd_i;
        in_word.sym      = symbol_i;
        in_word.last     = key_last_i;
        in_word.id       = key_id_i;
        if (walk_trie(in_word, new_result)) pending_results = {pending_results, new_result};
      end
    end
  end

  always @(posedge done_i) begin
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      leftover_cnt = pending_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the trie testbench: clock, reset, symbol stimulus, result draining and verdict.
`timescale 1ns / 100ps
module testbench;
  import tli_pkg::*;

  localparam logic            CMD_INSERT = 1'b0;
  localparam logic            CMD_QUERY  = 1'b1;
  localparam logic [SYM_W-1:0] L_A = 5'd0;
  localparam logic [SYM_W-1:0] L_B = 5'd1;
  localparam logic [SYM_W-1:0] L_C = 5'd2;
  localparam logic [SYM_W-1:0] L_D = 5'd3;
  localparam logic [SYM_W-1:0] L_Q = 5'd16;
  localparam logic [SYM_W-1:0] L_X = 5'd23;
  localparam logic [SYM_W-1:0] L_Y = 5'd24;
  localparam logic [SYM_W-1:0] L_Z = 5'd25;
  localparam logic [SYM_W-1:0] SYM_TOP  = 5'd31;
  localparam int   RANDOM_WORDS = 1100;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   CYCLE_LIMIT  = 1000000;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_e;

  // A short key of up to 8 symbols.
  typedef struct packed {
    logic [3:0]             len;
    logic [7:0][SYM_W-1:0]  sym;
  } key_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             push       = 1'b0;
  logic             full;
  logic             cmd        = CMD_INSERT;
  logic [SYM_W-1:0] symbol     = '0;
  logic             key_last   = 1'b0;
  logic [ID_W-1:0]  key_id     = '0;
  logic             empty;
  logic             pop        = 1'b0;
  logic [1:0]       status;
  logic [ID_W-1:0]  found_id;
  logic             done       = 1'b0;
  int               fail_count;

  int       words_sent    = 0;
  int       keys_sent     = 0;
  int       results_taken = 0;
  int       burst_left    = 0;
  int       hold_requests = 0;
  int       hold_seen     = 0;
  int       hold_left     = 0;
  int       rx_left       = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  int       cycle_cnt     = 0;
  key_t     known_keys [$];

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  trie_insert_lookup_max_id i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .cmd_i      (cmd),
    .symbol_i   (symbol),
    .key_last_i (key_last),
    .key_id_i   (key_id),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status),
    .found_id_o (found_id)
  );

  trie_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .cmd_i        (cmd),
    .symbol_i     (symbol),
    .key_last_i   (key_last),
    .key_id_i     (key_id),
    .empty_i      (empty),
    .pop_i        (pop),
    .status_i     (status),
    .found_id_i   (found_id),
    .done_i       (done),
    .fail_count_o (fail_count)
  );

  // Result side: stall pattern that changes mode now and then, plus long holds on request.
  always @(posedge clk) begin
    if (pop && !empty) results_taken++;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom_range(0, 1));
        RX_EVERY4: pop <= (rx_left % 4 == 0);
        default:   pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic c, input logic [SYM_W-1:0] s, input logic l,
                           input logic [ID_W-1:0] id);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    push     <= 1'b1;
    cmd      <= c;
    symbol   <= s;
    key_last <= l;
    key_id   <= id;
    do @(posedge clk); while (full);
    burst_left--;
    words_sent++;
    if (l) keys_sent++;
  endtask

  // Bit i of cmds is the command of symbol i.
  task automatic send_key(input key_t k, input logic [7:0] cmds, input logic [ID_W-1:0] id);
    for (int i = 0; i < k.len; i++) send_word(cmds[i], k.sym[i], i == k.len - 1, id);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (results_taken == keys_sent);
    @(posedge clk);
  endtask

  function automatic key_t mk_key(input int unsigned n, input logic [SYM_W-1:0] a,
                                  input logic [SYM_W-1:0] b = '0,
                                  input logic [SYM_W-1:0] c = '0);
    key_t k;
    k        = '0;
    k.len    = 4'(n);
    k.sym[0] = a;
    k.sym[1] = b;
    k.sym[2] = c;
    return k;
  endfunction

  // Mostly a narrow alphabet so that queries hit; sometimes any 5-bit code.
  function automatic key_t rand_key();
    key_t k;
    bit   wide;
    k    = '0;
    wide = ($urandom_range(0, 4) == 0);
    k.len = 4'($urandom_range(1, 6));
    for (int i = 0; i < 8; i++)
      k.sym[i] = wide ? SYM_W'($urandom_range(0, 31)) : SYM_W'($urandom_range(0, 3));
    return k;
  endfunction

  task automatic remember(input key_t k);
    if (known_keys.size() < 64) known_keys = {known_keys, k};
    else known_keys[$urandom_range(0, 63)] = k;
  endtask

  task automatic random_key();
    key_t        k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 || known_keys.size() == 0) begin
      k = rand_key();
      send_key(k, {8{CMD_INSERT}}, ID_W'($urandom));
      remember(k);
    end else if (pick < 75) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      // Prefixes reach inner nodes, which carry the latest id that passed through.
      if ($urandom_range(0, 2) == 0) k.len = 4'($urandom_range(1, k.len));
      send_key(k, {8{CMD_QUERY}}, ID_W'($urandom));
    end else if (pick < 80) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_key(k, {8{CMD_INSERT}}, ID_W'($urandom));
    end else if (pick < 92) begin
      send_key(rand_key(), {8{CMD_QUERY}}, ID_W'($urandom));
    end else begin
      send_key(rand_key(), 8'($urandom), ID_W'($urandom));
    end
  endtask

  initial begin
    int iter;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keys: empty trie, prefixes, misses, id extremes, symbol saturation,
    // and keys whose symbols mix insert and query.
    send_key(mk_key(1, L_A), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(1, SEP_SYMBOL), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(3, L_A, L_B, L_C), {8{CMD_INSERT}}, 16'h0001);
    send_key(mk_key(3, L_A, L_B, L_C), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(2, L_A, L_B), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(3, L_A, L_B, L_D), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(2, L_A, L_B), {8{CMD_INSERT}}, 16'hFFFF);
    send_key(mk_key(3, L_A, L_B, L_C), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(2, L_A, L_B), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(1, SYM_TOP), {8{CMD_INSERT}}, 16'h1234);
    send_key(mk_key(1, SEP_SYMBOL), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(1, SEP_SYMBOL + 5'd1), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(3, L_Q, L_Z, L_Z), {8{CMD_QUERY}}, 16'h0000);
    send_key(mk_key(2, L_X, L_Y), {6'b0, CMD_QUERY, CMD_INSERT}, 16'h0000);
    send_key(mk_key(2, L_A, L_Z), {6'b0, CMD_INSERT, CMD_QUERY}, 16'h0007);
    send_key(mk_key(2, L_A, L_Z), {8{CMD_QUERY}}, 16'h0000);

    iter = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (iter == 40 || iter == 180) hold_requests++;
      if (iter == 120) drain();
      random_key();
      iter++;
    end
    drain();

    // A last long hold while the sender keeps going.
    hold_requests++;
    for (int i = 0; i < 40; i++) random_key();

    drain();
    repeat (20) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
